// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/brtd_pkg.sv =====
// ----------------------------------------------------------------------------
// brtd_pkg
// shared types, constants and helpers of the touch detector
// ----------------------------------------------------------------------------
package brtd_pkg;

    localparam int unsigned ADC_W   = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned AMP_W   = 16;
    localparam int unsigned PLEN_W  = 8;
    localparam int unsigned PCT_W   = 10;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned REG_W   = 3;

    localparam int unsigned DEF_LOG2_UPSCALE      = 4;
    localparam int unsigned DEF_LOG2_FAST_WINDOW  = 4;
    localparam int unsigned DEF_LOG2_SLOW_WINDOW  = 10;
    localparam int unsigned DEF_BASELINE_INTERVAL = 64;
    localparam int unsigned DEF_HISTORY_LEN       = 8;

    localparam int unsigned PERCENT_DIV = 100;

    localparam logic [REG_W-1:0] REG_PERIOD_LENGTH  = 3'd0;
    localparam logic [REG_W-1:0] REG_ON_PERCENT     = 3'd1;
    localparam logic [REG_W-1:0] REG_OFF_PERCENT    = 3'd2;
    localparam logic [REG_W-1:0] REG_HOLD_TIME_MS   = 3'd3;
    localparam logic [REG_W-1:0] REG_WARMUP_PERIODS = 3'd4;

    localparam logic [PLEN_W-1:0] RST_PERIOD_LENGTH  = 8'd16;
    localparam logic [PCT_W-1:0]  RST_ON_PERCENT     = 10'd70;
    localparam logic [PCT_W-1:0]  RST_OFF_PERCENT    = 10'd80;
    localparam logic [MS_W-1:0]   RST_HOLD_TIME_MS   = 16'd100;
    localparam logic [CNT_W-1:0]  RST_WARMUP_PERIODS = 16'd100;

    localparam logic [CODE_W-1:0] FSM_RESET  = 2'd0;
    localparam logic [CODE_W-1:0] FSM_WARMUP = 2'd1;
    localparam logic [CODE_W-1:0] FSM_UNTRIG = 2'd2;
    localparam logic [CODE_W-1:0] FSM_TRIG   = 2'd3;

    typedef enum logic [3:0] {
        MODE_RESET  = 4'b0001,
        MODE_WARMUP = 4'b0010,
        MODE_UNTRIG = 4'b0100,
        MODE_TRIG   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [ADC_W-1:0]  adc_sample;
        logic [TIME_W-1:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic              lick_level;
        logic              lick_start;
        logic              lick_stop;
        logic [CODE_W-1:0] fsm_state;
        logic [AMP_W-1:0]  filtered_amplitude;
        logic [AMP_W-1:0]  baseline_level;
    } t_out_word;

    typedef struct packed {
        logic [PLEN_W-1:0] period_length;
        logic [PCT_W-1:0]  on_percent;
        logic [MS_W-1:0]   hold_time_ms;
        logic [CNT_W-1:0]  warmup_periods;
    } t_cfg;

    // avg * (2^lg - 1) / 2^lg + x / 2^lg, kept to the average width
    function automatic logic [AMP_W-1:0] iir_step(
        input logic [AMP_W-1:0] avg,
        input logic [AMP_W-1:0] x,
        input int unsigned      lg
    );
        logic [31:0] prod;
        logic [31:0] sum;
        prod = ({16'b0, avg} << lg) - {16'b0, avg};
        sum  = (prod >> lg) + ({16'b0, x} >> lg);
        return sum[AMP_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] mode_code(input t_mode m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_RESET:  c = FSM_RESET;
            MODE_WARMUP: c = FSM_WARMUP;
            MODE_UNTRIG: c = FSM_UNTRIG;
            MODE_TRIG:   c = FSM_TRIG;
            default:     c = FSM_RESET;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/brtd_cfg.sv =====
// ----------------------------------------------------------------------------
// brtd_cfg
// apb register file holding the detector settings
// ----------------------------------------------------------------------------
module brtd_cfg
    import brtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [PLEN_W-1:0] r_period_length;
    logic [PCT_W-1:0]  r_on_percent;
    logic [PCT_W-1:0]  r_off_percent;
    logic [MS_W-1:0]   r_hold_time_ms;
    logic [CNT_W-1:0]  r_warmup_periods;
    logic [REG_W-1:0]  reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_length  <= RST_PERIOD_LENGTH;
            r_on_percent     <= RST_ON_PERCENT;
            r_off_percent    <= RST_OFF_PERCENT;
            r_hold_time_ms   <= RST_HOLD_TIME_MS;
            r_warmup_periods <= RST_WARMUP_PERIODS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PERIOD_LENGTH:  r_period_length  <= pwdata[PLEN_W-1:0];
                REG_ON_PERCENT:     r_on_percent     <= pwdata[PCT_W-1:0];
                REG_OFF_PERCENT:    r_off_percent    <= pwdata[PCT_W-1:0];
                REG_HOLD_TIME_MS:   r_hold_time_ms   <= pwdata[MS_W-1:0];
                REG_WARMUP_PERIODS: r_warmup_periods <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PERIOD_LENGTH:  prdata = APB_DW'(r_period_length);
            REG_ON_PERCENT:     prdata = APB_DW'(r_on_percent);
            REG_OFF_PERCENT:    prdata = APB_DW'(r_off_percent);
            REG_HOLD_TIME_MS:   prdata = APB_DW'(r_hold_time_ms);
            REG_WARMUP_PERIODS: prdata = APB_DW'(r_warmup_periods);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.period_length  = r_period_length;
    assign o_cfg.on_percent     = r_on_percent;
    assign o_cfg.hold_time_ms   = r_hold_time_ms;
    assign o_cfg.warmup_periods = r_warmup_periods;

endmodule

// ===== hw/rtl/brtd_amp.sv =====
// ----------------------------------------------------------------------------
// brtd_amp
// per-period min/max tracking and upscaled peak-to-peak amplitude
// ----------------------------------------------------------------------------
module brtd_amp
    import brtd_pkg::*;
#(
    parameter int unsigned LOG2_UPSCALE = DEF_LOG2_UPSCALE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [ADC_W-1:0]  i_sample,
    input  logic [PLEN_W-1:0] i_period_length,
    output logic              o_period_end,
    output logic [AMP_W-1:0]  o_amplitude
);

    localparam logic [PLEN_W:0] FULL_LEN = (PLEN_W+1)'(1 << PLEN_W);

    logic [PLEN_W-1:0] r_idx;
    logic [ADC_W-1:0]  r_min;
    logic [ADC_W-1:0]  r_max;
    logic [ADC_W-1:0]  cur_min;
    logic [ADC_W-1:0]  cur_max;
    logic [ADC_W-1:0]  diff;
    logic [AMP_W-1:0]  diff_ext;
    logic [PLEN_W:0]   len;
    logic [PLEN_W:0]   idx_inc;

    always_comb begin
        if (r_idx == '0) begin
            cur_min = i_sample;
            cur_max = i_sample;
        end else begin
            cur_min = (i_sample < r_min) ? i_sample : r_min;
            cur_max = (i_sample > r_max) ? i_sample : r_max;
        end
    end

    // zero length means a full 256-sample period
    assign len          = (i_period_length == '0) ? FULL_LEN : {1'b0, i_period_length};
    assign idx_inc      = {1'b0, r_idx} + 1'b1;
    assign o_period_end = (idx_inc >= len);
    assign diff         = cur_max - cur_min;
    assign diff_ext     = AMP_W'(diff);
    assign o_amplitude  = diff_ext << LOG2_UPSCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_min <= '0;
            r_max <= '0;
        end else if (i_fire) begin
            r_min <= cur_min;
            r_max <= cur_max;
            r_idx <= o_period_end ? '0 : idx_inc[PLEN_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/brtd_det.sv =====
// ----------------------------------------------------------------------------
// brtd_det
// fast and baseline averages, threshold history and detection state machine
// ----------------------------------------------------------------------------
module brtd_det
    import brtd_pkg::*;
#(
    parameter int unsigned LOG2_FAST_WINDOW  = DEF_LOG2_FAST_WINDOW,
    parameter int unsigned LOG2_SLOW_WINDOW  = DEF_LOG2_SLOW_WINDOW,
    parameter int unsigned BASELINE_INTERVAL = DEF_BASELINE_INTERVAL,
    parameter int unsigned HISTORY_LEN       = DEF_HISTORY_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [AMP_W-1:0]  i_amplitude,
    input  logic [TIME_W-1:0] i_time,
    input  t_cfg              i_cfg,
    output t_out_word         o_result
);

    localparam int unsigned PROD_W = PCT_W + AMP_W + 1;
    localparam logic [CNT_W-1:0] BL_LAST = CNT_W'(BASELINE_INTERVAL);

    t_mode                  r_mode, n_mode;
    logic [AMP_W-1:0]       r_fast, n_fast;
    logic [AMP_W-1:0]       r_slow, n_slow;
    logic [CNT_W-1:0]       r_bcnt, n_bcnt;
    logic [CNT_W-1:0]       r_wcnt, n_wcnt;
    logic [HISTORY_LEN-1:0] r_bits, n_bits;
    logic                   r_hold, n_hold;
    logic [TIME_W-1:0]      r_start_stamp, n_start_stamp;
    logic [TIME_W-1:0]      r_stop_stamp, n_stop_stamp;
    logic [PROD_W-1:0]      on_prod;
    logic [PROD_W-1:0]      fast_scaled;
    logic [TIME_W-1:0]      since_start;
    logic [TIME_W-1:0]      since_stop;
    logic                   touch;
    logic                   start;
    logic                   stop;

    assign since_start = i_time - r_start_stamp;
    assign since_stop  = i_time - r_stop_stamp;

    // fast < on_percent * base / 100  <=>  100 * (fast + 1) <= on_percent * base
    assign on_prod     = PROD_W'(i_cfg.on_percent) * PROD_W'(n_slow);
    assign fast_scaled = (PROD_W'(n_fast) + 1'b1) * PROD_W'(PERCENT_DIV);
    assign touch       = (fast_scaled <= on_prod);

    always_comb begin
        n_mode        = r_mode;
        n_bcnt        = (r_bcnt == BL_LAST) ? '0 : r_bcnt + 1'b1;
        n_fast        = iir_step(r_fast, i_amplitude, LOG2_FAST_WINDOW);
        n_slow        = (n_bcnt == '0) ? iir_step(r_slow, i_amplitude, LOG2_SLOW_WINDOW)
                                       : r_slow;
        n_wcnt        = r_wcnt;
        n_bits        = r_bits;
        n_hold        = r_hold;
        n_start_stamp = r_start_stamp;
        n_stop_stamp  = r_stop_stamp;
        start         = 1'b0;
        stop          = 1'b0;

        if (r_mode == MODE_RESET) begin
            n_fast        = i_amplitude;
            n_slow        = i_amplitude;
            n_bcnt        = '0;
            n_wcnt        = '0;
            n_hold        = 1'b0;
            n_bits        = '0;
            n_start_stamp = i_time;
            n_stop_stamp  = i_time;
        end
        if (r_mode == MODE_TRIG) begin
            n_hold = (since_start > TIME_W'(i_cfg.hold_time_ms));
        end
        if (r_mode == MODE_UNTRIG) begin
            n_hold = (since_stop > TIME_W'(i_cfg.hold_time_ms));
        end
        if (r_mode == MODE_UNTRIG || r_mode == MODE_TRIG) begin
            n_bits = (r_bits << 1) | HISTORY_LEN'(touch);
        end

        unique case (r_mode)
            MODE_RESET: begin
                n_mode = MODE_WARMUP;
            end
            MODE_WARMUP: begin
                if (r_wcnt >= i_cfg.warmup_periods) begin
                    n_mode = MODE_UNTRIG;
                end
                if (r_wcnt != '1) begin
                    n_wcnt = r_wcnt + 1'b1;
                end
            end
            MODE_UNTRIG: begin
                if ((&n_bits) && n_hold) begin
                    n_mode        = MODE_TRIG;
                    n_start_stamp = i_time;
                    start         = 1'b1;
                end
            end
            MODE_TRIG: begin
                if ((n_bits == '0) && n_hold) begin
                    n_mode       = MODE_UNTRIG;
                    n_stop_stamp = i_time;
                    stop         = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_RESET;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RESET;
            r_fast        <= '0;
            r_slow        <= '0;
            r_bcnt        <= '0;
            r_wcnt        <= '0;
            r_bits        <= '0;
            r_hold        <= 1'b0;
            r_start_stamp <= '0;
            r_stop_stamp  <= '0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_fast        <= n_fast;
            r_slow        <= n_slow;
            r_bcnt        <= n_bcnt;
            r_wcnt        <= n_wcnt;
            r_bits        <= n_bits;
            r_hold        <= n_hold;
            r_start_stamp <= n_start_stamp;
            r_stop_stamp  <= n_stop_stamp;
        end
    end

    assign o_result.lick_level         = (n_mode == MODE_TRIG);
    assign o_result.lick_start         = start;
    assign o_result.lick_stop          = stop;
    assign o_result.fsm_state          = mode_code(n_mode);
    assign o_result.filtered_amplitude = n_fast;
    assign o_result.baseline_level     = n_slow;

endmodule

// ===== hw/rtl/baseline_relative_touch_detector.sv =====
// ----------------------------------------------------------------------------
// baseline_relative_touch_detector
// Takes one converter sample word per cycle, when not stalled, into an input
// register; from that register it updates the period min/max and, on the last
// sample of a period, the averages, threshold history and detection state,
// loading one result word into the output register. The sustained rate is one
// sample word per cycle while the output is not stalled, set by the compute
// logic whose longest path is the baseline average feeding the 10x16 threshold
// multiply and compare. The input stalls only while a period-end word waits
// for a full, stalled output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module baseline_relative_touch_detector
    import brtd_pkg::*;
#(
    parameter int unsigned LOG2_UPSCALE      = DEF_LOG2_UPSCALE,
    parameter int unsigned LOG2_FAST_WINDOW  = DEF_LOG2_FAST_WINDOW,
    parameter int unsigned LOG2_SLOW_WINDOW  = DEF_LOG2_SLOW_WINDOW,
    parameter int unsigned BASELINE_INTERVAL = DEF_BASELINE_INTERVAL,
    parameter int unsigned HISTORY_LEN       = DEF_HISTORY_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    logic             r_s1_valid;
    t_in_word         r_s1;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        result;
    logic             period_end;
    logic [AMP_W-1:0] amplitude;
    logic             out_free;
    logic             fire;
    logic             fire_end;
    logic             in_accept;

    brtd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    brtd_amp #(
        .LOG2_UPSCALE (LOG2_UPSCALE)
    ) u_amp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_sample        (r_s1.adc_sample),
        .i_period_length (cfg.period_length),
        .o_period_end    (period_end),
        .o_amplitude     (amplitude)
    );

    brtd_det #(
        .LOG2_FAST_WINDOW  (LOG2_FAST_WINDOW),
        .LOG2_SLOW_WINDOW  (LOG2_SLOW_WINDOW),
        .BASELINE_INTERVAL (BASELINE_INTERVAL),
        .HISTORY_LEN       (HISTORY_LEN)
    ) u_det (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire_end),
        .i_amplitude (amplitude),
        .i_time      (r_s1.time_ms),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && (!period_end || out_free);
    assign fire_end   = fire && period_end;
    assign o_in_stall = r_s1_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_end) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a word shows up only after a sample sat in the input register
    `ASSERT_IMPLIES(a_out_from_stage, i_clk, i_rst_n, $rose(o_out_valid), $past(r_s1_valid), "output word without a staged sample")
    // level follows the triggered state
    `ASSERT_IMPLIES(a_level_state, i_clk, i_rst_n, o_out_valid, o_out_word.lick_level == (o_out_word.fsm_state == FSM_TRIG), "lick level does not match state")
    // start and stop never in the same word
    `ASSERT_NEVER(a_start_stop, i_clk, i_rst_n, o_out_valid && o_out_word.lick_start && o_out_word.lick_stop, "start and stop together")
    // a start lands in the triggered state
    `ASSERT_IMPLIES(a_start_trig, i_clk, i_rst_n, o_out_valid && o_out_word.lick_start, o_out_word.fsm_state == FSM_TRIG, "start outside triggered state")

endmodule

// ===== test/touch_report_checker.sv =====
// ----------------------------------------------------------------------------
// touch_report_checker
// Watches the sample, report and register ports of the touch detector. It
// keeps its own copy of the detector state and settings, predicts the report
// of each period end and compares every report word field by field with the
// oldest prediction. Mismatches and queue depth go back to the testbench top.
// ----------------------------------------------------------------------------
module touch_report_checker
    import brtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_word          i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_word         i_out_word,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_reports
);

    logic [PLEN_W-1:0] cfg_period;
    logic [PCT_W-1:0]  cfg_on;
    logic [PCT_W-1:0]  cfg_off;
    logic [MS_W-1:0]   cfg_hold;
    logic [CNT_W-1:0]  cfg_warm;

    logic [CODE_W-1:0]          mode;
    logic [ADC_W-1:0]           pmin;
    logic [ADC_W-1:0]           pmax;
    logic [PLEN_W-1:0]          idx;
    logic [AMP_W-1:0]           fast;
    logic [AMP_W-1:0]           slow;
    logic [CNT_W-1:0]           bcnt;
    logic [CNT_W-1:0]           wcnt;
    logic [DEF_HISTORY_LEN-1:0] hist;
    logic                       held;
    logic [TIME_W-1:0]          start_ts;
    logic [TIME_W-1:0]          stop_ts;

    t_out_word queued_touch_reports[$];
    int        mismatch_count = 0;
    int        report_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_reports    = report_count;

    function automatic logic [AMP_W-1:0] smooth(
        input logic [AMP_W-1:0] avg,
        input logic [AMP_W-1:0] x,
        input int unsigned      lg
    );
        logic [31:0] acc;
        acc = ((32'(avg) * ((32'd1 << lg) - 32'd1)) >> lg) + (32'(x) >> lg);
        return acc[AMP_W-1:0];
    endfunction

    task automatic clear_detector();
        cfg_period = RST_PERIOD_LENGTH;
        cfg_on     = RST_ON_PERCENT;
        cfg_off    = RST_OFF_PERCENT;
        cfg_hold   = RST_HOLD_TIME_MS;
        cfg_warm   = RST_WARMUP_PERIODS;
        mode       = FSM_RESET;
        pmin       = '0;
        pmax       = '0;
        idx        = '0;
        fast       = '0;
        slow       = '0;
        bcnt       = '0;
        wcnt       = '0;
        hist       = '0;
        held       = 1'b0;
        start_ts   = '0;
        stop_ts    = '0;
        queued_touch_reports.delete();
    endtask

    task automatic advance_detector(input logic [ADC_W-1:0] smp, input logic [TIME_W-1:0] stamp);
        int unsigned       span;
        logic [AMP_W-1:0]  up;
        logic [31:0]       on_level;
        logic [CODE_W-1:0] nxt;
        logic              start_pulse;
        logic              stop_pulse;
        t_out_word         rep;
        span        = (cfg_period == '0) ? 256 : cfg_period;
        start_pulse = 1'b0;
        stop_pulse  = 1'b0;
        if (idx == '0) begin
            pmin = smp;
            pmax = smp;
        end else begin
            if (smp < pmin) pmin = smp;
            if (smp > pmax) pmax = smp;
        end
        if (idx + 1 < span) begin
            idx = idx + 1'b1;
            return;
        end
        idx = '0;
        up = AMP_W'((32'(pmax) - 32'(pmin)) << DEF_LOG2_UPSCALE);
        bcnt = (bcnt == DEF_BASELINE_INTERVAL) ? '0 : bcnt + 1'b1;

        if (mode != FSM_RESET) begin
            fast = smooth(fast, up, DEF_LOG2_FAST_WINDOW);
            if (bcnt == '0) slow = smooth(slow, up, DEF_LOG2_SLOW_WINDOW);
        end else begin
            fast     = up;
            slow     = up;
            bcnt     = '0;
            wcnt     = '0;
            held     = 1'b0;
            hist     = '0;
            start_ts = stamp;
            stop_ts  = stamp;
        end

        if (mode == FSM_TRIG) held = (stamp - start_ts) > 32'(cfg_hold);
        if (mode == FSM_UNTRIG) held = (stamp - stop_ts) > 32'(cfg_hold);

        on_level = (32'(cfg_on) * 32'(slow)) / PERCENT_DIV;
        if (mode == FSM_UNTRIG || mode == FSM_TRIG) begin
            hist = {hist[DEF_HISTORY_LEN-2:0], (32'(fast) < on_level)};
        end

        nxt = mode;
        case (mode)
            FSM_RESET: begin
                nxt = FSM_WARMUP;
            end
            FSM_WARMUP: begin
                if (wcnt >= cfg_warm) nxt = FSM_UNTRIG;
                if (wcnt != '1) wcnt = wcnt + 1'b1;
            end
            FSM_UNTRIG: begin
                if (&hist && held) begin
                    nxt         = FSM_TRIG;
                    start_ts    = stamp;
                    start_pulse = 1'b1;
                end
            end
            default: begin
                if (hist == '0 && held) begin
                    nxt        = FSM_UNTRIG;
                    stop_ts    = stamp;
                    stop_pulse = 1'b1;
                end
            end
        endcase
        mode = nxt;

        rep.lick_level         = (mode == FSM_TRIG);
        rep.lick_start         = start_pulse;
        rep.lick_stop          = stop_pulse;
        rep.fsm_state          = mode;
        rep.filtered_amplitude = fast;
        rep.baseline_level     = slow;
        queued_touch_reports.push_back(rep);
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch in %s: expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_detector();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_PERIOD_LENGTH:  cfg_period = i_pwdata[PLEN_W-1:0];
                    REG_ON_PERCENT:     cfg_on     = i_pwdata[PCT_W-1:0];
                    REG_OFF_PERCENT:    cfg_off    = i_pwdata[PCT_W-1:0];
                    REG_HOLD_TIME_MS:   cfg_hold   = i_pwdata[MS_W-1:0];
                    REG_WARMUP_PERIODS: cfg_warm   = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                report_count++;
                if (queued_touch_reports.size() == 0) begin
                    $display("%0t unexpected report %h with nothing predicted", $time, i_out_word);
                    mismatch_count++;
                end else begin
                    want = queued_touch_reports.pop_front();
                    check_field("lick_level", want.lick_level, i_out_word.lick_level);
                    check_field("lick_start", want.lick_start, i_out_word.lick_start);
                    check_field("lick_stop", want.lick_stop, i_out_word.lick_stop);
                    check_field("fsm_state", want.fsm_state, i_out_word.fsm_state);
                    check_field("filtered_amplitude", want.filtered_amplitude,
                                i_out_word.filtered_amplitude);
                    check_field("baseline_level", want.baseline_level,
                                i_out_word.baseline_level);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_detector(i_in_word.adc_sample, i_in_word.time_ms);
            end
        end
        o_pending <= queued_touch_reports.size();
    end

endmodule

// ===== test/tb_baseline_relative_touch_detector.sv =====
// ----------------------------------------------------------------------------
// tb_baseline_relative_touch_detector
// Drives sample words and register writes into the touch detector: a short
// directed opening with field extremes and a shortened period, then phases of
// touch and release bursts under several settings, with random gaps and
// output stalls. The report checker predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_baseline_relative_touch_detector;
    import brtd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_word          i_in_word;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_word         o_out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                pending;
    int                reports;
    int                words_sent = 0;
    int                settings_used = 0;
    int                cycle_count = 0;
    bit                calm = 1'b0;
    logic [TIME_W-1:0] clock_ms;

    baseline_relative_touch_detector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    touch_report_checker report_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_reports   (reports)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // report side back-pressure
    initial begin
        int hold_n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold_n = calm ? 0 : $urandom_range(0, 5);
            if (hold_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_word(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{adc_sample: adc, time_ms: stamp};
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int plen, input int on_pct, input int off_pct,
                                  input int hold_ms, input int warm);
        settle();
        write_reg(REG_PERIOD_LENGTH, plen);
        write_reg(REG_ON_PERCENT, on_pct);
        write_reg(REG_OFF_PERCENT, off_pct);
        write_reg(REG_HOLD_TIME_MS, hold_ms);
        write_reg(REG_WARMUP_PERIODS, warm);
        settings_used++;
    endtask

    // bursts of wide swings (release) and flat levels (touch), some noise
    task automatic random_phase(input int count, input int span, input bit pause_midway);
        int               k;
        int               burst_left;
        int               kind;
        logic [ADC_W-1:0] floor_lvl;
        logic [ADC_W-1:0] smp;
        burst_left = 0;
        kind       = 0;
        floor_lvl  = '0;
        for (k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(3, 40) * span;
                kind       = $urandom_range(0, 9);
                floor_lvl  = ADC_W'($urandom_range(0, 4030));
            end
            burst_left--;
            if (kind < 5)
                smp = k[0] ? ADC_W'($urandom_range(3900, 4095)) : ADC_W'($urandom_range(0, 200));
            else if (kind < 9)
                smp = floor_lvl + ADC_W'($urandom_range(0, 60));
            else
                smp = ADC_W'($urandom());
            if ($urandom_range(0, 39) == 0)
                clock_ms += $urandom_range(0, 100000);
            else
                clock_ms += $urandom_range(0, 20);
            send_word(smp, clock_ms);
            if (pause_midway && k == count / 2) drain();
        end
    endtask

    initial begin
        int i;
        int on_pct;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        clock_ms   = 32'hFFFF_F000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first period sets the baseline at full swing
        for (i = 0; i < 16; i++) begin
            send_word((i == 0) ? 12'h000 : (i == 1) ? 12'hFFF : ADC_W'(i * 273),
                      (i == 15) ? 32'hFFFF_FFFF : TIME_W'(i));
        end
        for (i = 0; i < 9; i++) send_word(12'hFFF, 32'h0);
        // shorter period written mid-period ends it on the next sample
        settle();
        write_reg(REG_PERIOD_LENGTH, 3);
        send_word(12'h000, 32'h0000_0040);

        apply_settings(2, 70, 80, 0, 0);
        calm = 1'b0;
        random_phase(60, 2, 1'b0);

        apply_settings(1, 1000, 1000, 65535, 65535);
        calm = 1'b1;
        random_phase(20, 1, 1'b0);

        apply_settings(3, 0, 0, 5, 3);
        calm = 1'b0;
        random_phase(36, 3, 1'b0);

        apply_settings(0, 75, 85, 20, 0);
        calm = 1'b1;
        random_phase(260, 256, 1'b0);

        apply_settings(7, 65, 70, 10, 0);
        calm = 1'b0;
        random_phase(28, 7, 1'b0);

        on_pct = $urandom_range(40, 95);
        apply_settings($urandom_range(2, 6), on_pct, on_pct + $urandom_range(0, 20),
                       $urandom_range(0, 50), $urandom_range(0, 3));
        calm = 1'b0;
        random_phase(40, 4, 1'b1);

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d sample words and %0d detector reports under %0d settings",
                 words_sent, reports, settings_used + 2);
        $display("period lengths 1 to 256, thresholds 0 to 1000 percent, hold 0 to 65535 ms");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== baseline_relative_touch_detector.f =====
+incdir+hw/rtl
hw/rtl/brtd_pkg.sv
hw/rtl/brtd_cfg.sv
hw/rtl/brtd_amp.sv
hw/rtl/brtd_det.sv
hw/rtl/baseline_relative_touch_detector.sv
test/touch_report_checker.sv
test/tb_baseline_relative_touch_detector.sv
